// ----- design/tpfm_pkg.sv -----
// shared types, constants and helpers for the tile pixel fifo mixer
package tpfm_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int ROW_PIXELS = 8;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int ROW_IDX_W  = $clog2(ROW_PIXELS);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    CMD_PUSH_BG  = 2'd0,
    CMD_PUSH_OBJ = 2'd1,
    CMD_SHIFT    = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_ENABLE  = 3'd0,
    CFG_OBJ_ENABLE = 3'd1,
    CFG_BG_PAL     = 3'd2,
    CFG_OBJ_PAL0   = 3'd3,
    CFG_OBJ_PAL1   = 3'd4
  } cfg_idx_t;

  localparam logic       RST_BG_ENABLE  = 1'b1;
  localparam logic       RST_OBJ_ENABLE = 1'b0;
  localparam logic [7:0] RST_BG_PAL     = 8'd252;
  localparam logic [7:0] RST_OBJ_PAL    = 8'd0;

  typedef struct packed {
    logic [1:0] color;
    logic       pal;
    logic       behind;
    logic [7:0] x;
  } obj_entry_t;

  typedef struct packed {
    logic push;
    logic shift;
    logic held;
  } lane_ctl_t;

  typedef struct packed {
    logic       bg_enable;
    logic       obj_enable;
    logic [7:0] bg_pal;
    logic [7:0] obj_pal0;
    logic [7:0] obj_pal1;
  } cfg_t;

  // bit 7 is the leftmost pixel unless mirrored
  function automatic logic [1:0] row_color(input logic [7:0] hi, input logic [7:0] lo,
                                           input logic [ROW_IDX_W-1:0] k, input logic flip);
    logic [ROW_IDX_W-1:0] b;
    b = flip ? k : ROW_IDX_W'(ROW_PIXELS - 1) - k;
    return {hi[b], lo[b]};
  endfunction

  function automatic logic [1:0] pal_lookup(input logic [7:0] pal, input logic [1:0] color);
    return pal[{color, 1'b1} -: 2];
  endfunction

endpackage

// ----- design/tpfm_if.sv -----
// handshake channels: pixel commands in, shaded pixels out, register writes
interface tpfm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] plane_high;
  logic [7:0] plane_low;
  logic       obj_flip_x;
  logic       obj_pal_sel;
  logic       obj_behind_bg;
  logic [7:0] obj_x_pos;
  modport source (output valid, cmd, plane_high, plane_low, obj_flip_x, obj_pal_sel,
                  obj_behind_bg, obj_x_pos, input ready);
  modport sink (input valid, cmd, plane_high, plane_low, obj_flip_x, obj_pal_sel,
                obj_behind_bg, obj_x_pos, output ready);
endinterface

interface tpfm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade;
  logic       from_object;
  modport source (output valid, shade, from_object, input ready);
  modport sink (input valid, shade, from_object, output ready);
endinterface

interface tpfm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] addr;
  logic [7:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- design/tile_pixel_fifo_mixer_unit.sv -----
// top level: background and object pixel fifos with output mixer
// one item per cycle sustained, every command, while the output is taken; a shift's
// pixel is captured in the output register when the shift is accepted, and
// input stays open while that register is empty or is taken in the same cycle
// each fifo slot is its own lane, so a whole row is pushed or merged in parallel
// synchronous reset empties both fifos and loads the register defaults
module tile_pixel_fifo_mixer_unit (
  input  logic       clk,
  input  logic       rst,
  tpfm_in_if.sink    pix_in,
  tpfm_out_if.source pix_out,
  tpfm_cfg_if.sink   cfg
);
  import tpfm_pkg::*;

  cfg_t                    regs;
  logic [1:0]              bg_colors [FIFO_DEPTH];
  logic [FILL_W-1:0]       bg_fill;
  logic [FILL_W-1:0]       bg_fill_next;
  logic [FILL_W-1:0]       obj_fill;
  logic [FILL_W-1:0]       obj_fill_next;
  logic [FILL_W:0]         bg_sum;
  obj_entry_t              obj_q [FIFO_DEPTH];
  obj_entry_t              obj_px [ROW_PIXELS];
  logic [1:0]              bg_row [ROW_PIXELS];
  logic                    accept;
  logic                    do_push_bg;
  logic                    do_push_obj;
  logic                    do_shift;
  logic                    out_valid;
  logic [1:0]              mix_shade;
  logic                    mix_from_obj;

  assign accept      = pix_in.valid && pix_in.ready;
  assign do_push_bg  = accept && (pix_in.cmd == CMD_PUSH_BG);
  assign do_push_obj = accept && (pix_in.cmd == CMD_PUSH_OBJ);
  assign do_shift    = accept && (pix_in.cmd == CMD_SHIFT);
  assign pix_in.ready = !out_valid || pix_out.ready;
  assign cfg.ready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.bg_enable  <= RST_BG_ENABLE;
      regs.obj_enable <= RST_OBJ_ENABLE;
      regs.bg_pal     <= RST_BG_PAL;
      regs.obj_pal0   <= RST_OBJ_PAL;
      regs.obj_pal1   <= RST_OBJ_PAL;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_BG_ENABLE:  regs.bg_enable  <= cfg.data[0];
        CFG_OBJ_ENABLE: regs.obj_enable <= cfg.data[0];
        CFG_BG_PAL:     regs.bg_pal     <= cfg.data;
        CFG_OBJ_PAL0:   regs.obj_pal0   <= cfg.data;
        CFG_OBJ_PAL1:   regs.obj_pal1   <= cfg.data;
        default: ;
      endcase
    end
  end

  // decoded row pixels
  always_comb begin
    for (int k = 0; k < ROW_PIXELS; k++) begin
      bg_row[k] = row_color(pix_in.plane_high, pix_in.plane_low, ROW_IDX_W'(k), 1'b0);
      obj_px[k].color  = row_color(pix_in.plane_high, pix_in.plane_low, ROW_IDX_W'(k),
                                   pix_in.obj_flip_x);
      obj_px[k].pal    = pix_in.obj_pal_sel;
      obj_px[k].behind = pix_in.obj_behind_bg;
      obj_px[k].x      = pix_in.obj_x_pos;
    end
  end

  // background fifo: row lands after the current fill, surplus dropped
  for (genvar j = 0; j < FIFO_DEPTH; j++) begin : g_bg
    logic [FILL_W-1:0] off;
    logic              wr;
    assign off = FILL_W'(j) - bg_fill;
    assign wr  = (bg_fill <= FILL_W'(j)) && (off < FILL_W'(ROW_PIXELS));
    always_ff @(posedge clk) begin
      if (do_shift) begin
        if (j < FIFO_DEPTH - 1) begin
          bg_colors[j] <= bg_colors[(j + 1) % FIFO_DEPTH];
        end
      end else if (do_push_bg && wr) begin
        bg_colors[j] <= bg_row[off[ROW_IDX_W-1:0]];
      end
    end
  end

  assign bg_sum = {1'b0, bg_fill} + (FILL_W + 1)'(ROW_PIXELS);

  always_comb begin
    bg_fill_next = bg_fill;
    if (do_shift && (bg_fill != '0)) begin
      bg_fill_next = bg_fill - 1'b1;
    end else if (do_push_bg) begin
      bg_fill_next = (bg_sum > (FILL_W + 1)'(FIFO_DEPTH)) ? FILL_W'(FIFO_DEPTH)
                                                           : bg_sum[FILL_W-1:0];
    end
  end

  // object fifo lanes
  for (genvar j = 0; j < FIFO_DEPTH; j++) begin : g_obj
    lane_ctl_t  ctl;
    obj_entry_t px;
    assign ctl.shift = do_shift;
    assign ctl.push  = do_push_obj && (j < ROW_PIXELS);
    assign ctl.held  = FILL_W'(j) < obj_fill;
    if (j < ROW_PIXELS) begin : g_px
      assign px = obj_px[j];
    end else begin : g_nopx
      assign px = '0;
    end
    tpfm_obj_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .px       (px),
      .shift_in (obj_q[(j + 1 < FIFO_DEPTH) ? j + 1 : j]),
      .q        (obj_q[j])
    );
  end

  always_comb begin
    obj_fill_next = obj_fill;
    if (do_shift && (obj_fill != '0)) begin
      obj_fill_next = obj_fill - 1'b1;
    end else if (do_push_obj && (obj_fill < FILL_W'(ROW_PIXELS))) begin
      obj_fill_next = FILL_W'(ROW_PIXELS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_fill  <= '0;
      obj_fill <= '0;
    end else begin
      bg_fill  <= bg_fill_next;
      obj_fill <= obj_fill_next;
    end
  end

  tpfm_mixer u_mixer (
    .cfg          (regs),
    .bg_nonempty  (bg_fill != '0),
    .bg_front     (bg_colors[0]),
    .obj_nonempty (obj_fill != '0),
    .obj_front    (obj_q[0]),
    .shade        (mix_shade),
    .from_object  (mix_from_obj)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_shift) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      pix_out.shade       <= mix_shade;
      pix_out.from_object <= mix_from_obj;
    end
  end

  assign pix_out.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_bg_fill_bound: assert property (@(posedge clk) disable iff (rst)
    bg_fill <= FILL_W'(FIFO_DEPTH)) else $error("background fill beyond depth");

  a_obj_fill_bound: assert property (@(posedge clk) disable iff (rst)
    obj_fill <= FILL_W'(FIFO_DEPTH)) else $error("object fill beyond depth");

  a_out_from_shift: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(do_shift)) else $error("result without a shift");

  a_obj_push_fill: assert property (@(posedge clk) disable iff (rst)
    (do_push_obj && (obj_fill < FILL_W'(ROW_PIXELS))) |=> (obj_fill == FILL_W'(ROW_PIXELS)))
    else $error("object push did not fill a row");

  a_bg_pop: assert property (@(posedge clk) disable iff (rst)
    (do_shift && (bg_fill != '0)) |=> (bg_fill == $past(bg_fill) - 1'b1))
    else $error("background shift did not pop");
`endif

endmodule

// ----- design/tpfm_obj_lane.sv -----
// one object fifo slot: shift, merge against a new row pixel, or append
module tpfm_obj_lane (
  input  logic                  clk,
  input  tpfm_pkg::lane_ctl_t   ctl,
  input  tpfm_pkg::obj_entry_t  px,
  input  tpfm_pkg::obj_entry_t  shift_in,
  output tpfm_pkg::obj_entry_t  q
);
  import tpfm_pkg::*;

  obj_entry_t slot;
  logic       replace;

  // a held pixel loses when transparent or further right
  assign replace = (slot.color == 2'd0) || (slot.x > px.x);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      slot <= shift_in;
    end else if (ctl.push) begin
      if (!ctl.held || replace) begin
        slot <= px;
      end
    end
  end

  assign q = slot;

endmodule

// ----- design/tpfm_mixer.sv -----
// picks background or object front pixel and maps it through its palette
module tpfm_mixer (
  input  tpfm_pkg::cfg_t        cfg,
  input  logic                  bg_nonempty,
  input  logic [1:0]            bg_front,
  input  logic                  obj_nonempty,
  input  tpfm_pkg::obj_entry_t  obj_front,
  output logic [1:0]            shade,
  output logic                  from_object
);
  import tpfm_pkg::*;

  logic [1:0] bgc;
  logic [7:0] obj_pal;

  always_comb begin
    bgc         = bg_nonempty ? bg_front : 2'd0;
    from_object = obj_nonempty && cfg.obj_enable && (obj_front.color != 2'd0) &&
                  !(obj_front.behind && (bgc != 2'd0));
    obj_pal     = obj_front.pal ? cfg.obj_pal1 : cfg.obj_pal0;
    if (from_object) begin
      shade = pal_lookup(obj_pal, obj_front.color);
    end else if (cfg.bg_enable) begin
      shade = pal_lookup(cfg.bg_pal, bgc);
    end else begin
      shade = 2'd0;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the tile pixel fifo mixer: directed table, then random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpfm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 4;
  localparam int SCRIPT_ROWS   = 30;
  localparam int SEGS_PER_MODE = 4;
  localparam int ITEMS_PER_SEG = 120;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] hi;
    logic [7:0] lo;
    logic       flip;
    logic       pal;
    logic       behind;
    logic [7:0] x;
  } pix_item_t;

  typedef struct packed {
    logic [1:0] shade;
    logic       from_object;
  } shaded_px_t;

  typedef struct packed {
    logic       is_write;
    cfg_idx_t   reg_idx;
    logic [7:0] reg_val;
    pix_item_t  item;
    logic       typed;
    shaded_px_t want;
  } script_row_t;

  logic clk;
  logic rst;

  tpfm_in_if  pix_in ();
  tpfm_out_if pix_out ();
  tpfm_cfg_if cfg ();

  tile_pixel_fifo_mixer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  // predicted block state
  logic [1:0] bg_line [FIFO_DEPTH];
  int         bg_count;
  obj_entry_t obj_line [FIFO_DEPTH];
  int         obj_count;
  cfg_t       regs;

  shaded_px_t pixels_due [$];
  int         mismatches;
  int         src_idle;
  int         sink_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [1:0] tile_pixel(input pix_item_t it, input int k, input logic mirror);
    int b;
    b = mirror ? k : 7 - k;
    return {it.hi[b], it.lo[b]};
  endfunction

  function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] c);
    return pal[2 * c +: 2];
  endfunction

  task automatic mix_step(input pix_item_t it, output logic makes_px, output shaded_px_t px);
    int         held;
    obj_entry_t e;
    logic [1:0] front;
    logic       wins;
    logic [7:0] pal;
    makes_px = 1'b0;
    px = '0;
    case (it.cmd)
      CMD_PUSH_BG: begin
        for (int k = 0; k < 8; k++) begin
          if (bg_count < FIFO_DEPTH) begin
            bg_line[bg_count] = tile_pixel(it, k, 1'b0);
            bg_count++;
          end
        end
      end
      CMD_PUSH_OBJ: begin
        held = obj_count;
        for (int k = 0; k < 8; k++) begin
          e = '{tile_pixel(it, k, it.flip), it.pal, it.behind, it.x};
          if (k < held) begin
            // held slot: transparent or further right loses
            if (obj_line[k].color == 2'd0 || obj_line[k].x > e.x) obj_line[k] = e;
          end else if (obj_count < FIFO_DEPTH) begin
            obj_line[obj_count] = e;
            obj_count++;
          end
        end
      end
      CMD_SHIFT: begin
        front = (bg_count != 0) ? bg_line[0] : 2'd0;
        wins = (obj_count != 0) && !(obj_line[0].behind && front != 2'd0) &&
               regs.obj_enable && (obj_line[0].color != 2'd0);
        if (wins) begin
          pal = obj_line[0].pal ? regs.obj_pal1 : regs.obj_pal0;
          px.shade = shade_of(pal, obj_line[0].color);
        end else begin
          px.shade = regs.bg_enable ? shade_of(regs.bg_pal, front) : 2'd0;
        end
        px.from_object = wins;
        makes_px = 1'b1;
        if (obj_count != 0) begin
          for (int k = 0; k < FIFO_DEPTH - 1; k++) obj_line[k] = obj_line[k + 1];
          obj_count--;
        end
        if (bg_count != 0) begin
          for (int k = 0; k < FIFO_DEPTH - 1; k++) bg_line[k] = bg_line[k + 1];
          bg_count--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_pixel_cmd(input pix_item_t it, input logic typed, input shaded_px_t want);
    logic       makes_px;
    shaded_px_t px;
    while ($urandom_range(99) < src_idle) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid         <= 1'b1;
    pix_in.cmd           <= it.cmd;
    pix_in.plane_high    <= it.hi;
    pix_in.plane_low     <= it.lo;
    pix_in.obj_flip_x    <= it.flip;
    pix_in.obj_pal_sel   <= it.pal;
    pix_in.obj_behind_bg <= it.behind;
    pix_in.obj_x_pos     <= it.x;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    mix_step(it, makes_px, px);
    if (makes_px) pixels_due.push_back(typed ? want : px);
  endtask

  // registers change only once the pipe has drained
  task automatic load_register(input cfg_idx_t idx, input logic [7:0] val);
    pix_in.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_BG_ENABLE:  regs.bg_enable  = val[0];
      CFG_OBJ_ENABLE: regs.obj_enable = val[0];
      CFG_BG_PAL:     regs.bg_pal     = val;
      CFG_OBJ_PAL0:   regs.obj_pal0   = val;
      CFG_OBJ_PAL1:   regs.obj_pal1   = val;
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic script_row_t cmd_row(input logic [1:0] cmd, input logic [7:0] hi,
                                          input logic [7:0] lo, input logic flip,
                                          input logic pal, input logic behind,
                                          input logic [7:0] x);
    script_row_t row;
    row = '0;
    row.item = '{cmd, hi, lo, flip, pal, behind, x};
    return row;
  endfunction

  function automatic script_row_t shift_row(input logic [1:0] shade, input logic from_obj);
    script_row_t row;
    row = cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    row.typed = 1'b1;
    row.want = '{shade, from_obj};
    return row;
  endfunction

  function automatic script_row_t reg_row(input cfg_idx_t idx, input logic [7:0] val);
    script_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic pix_item_t random_item(input int bg_pct, input int obj_pct);
    pix_item_t it;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 3) it.cmd = CMD_UNUSED;
    else if (roll < 3 + bg_pct) it.cmd = CMD_PUSH_BG;
    else if (roll < 3 + bg_pct + obj_pct) it.cmd = CMD_PUSH_OBJ;
    else it.cmd = CMD_SHIFT;
    it.hi     = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
    it.lo     = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
    it.flip   = 1'($urandom_range(1));
    it.pal    = 1'($urandom_range(1));
    it.behind = 1'($urandom_range(1));
    // close x values make the merge decision go both ways
    it.x      = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
    return it;
  endfunction

  always @(posedge clk) pix_out.ready <= ($urandom_range(99) >= sink_idle);

  always @(posedge clk) begin : check_pixels
    shaded_px_t due;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel: shade %0d from_object %0d", pix_out.shade,
               pix_out.from_object);
        mismatches++;
      end else begin
        due = pixels_due.pop_front();
        if (pix_out.shade !== due.shade) begin
          $error("shade mismatch: expected %0d, actual %0d", due.shade, pix_out.shade);
          mismatches++;
        end
        if (pix_out.from_object !== due.from_object) begin
          $error("from_object mismatch: expected %0d, actual %0d", due.from_object,
                 pix_out.from_object);
          mismatches++;
        end
      end
    end
  end

  initial begin
    script_row_t script [SCRIPT_ROWS];
    pix_item_t   it;
    logic        en_bg;
    logic        en_obj;
    logic [7:0]  p_bg;
    logic [7:0]  p_o0;
    logic [7:0]  p_o1;
    int          seg;
    int          bg_pct;
    int          obj_pct;

    rst                  <= 1'b1;
    pix_in.valid         <= 1'b0;
    pix_in.cmd           <= CMD_SHIFT;
    pix_in.plane_high    <= 8'h00;
    pix_in.plane_low     <= 8'h00;
    pix_in.obj_flip_x    <= 1'b0;
    pix_in.obj_pal_sel   <= 1'b0;
    pix_in.obj_behind_bg <= 1'b0;
    pix_in.obj_x_pos     <= 8'h00;
    cfg.valid            <= 1'b0;
    cfg.addr             <= CFG_BG_ENABLE;
    cfg.data             <= 8'h00;
    mismatches = 0;
    bg_count = 0;
    obj_count = 0;
    regs = '{RST_BG_ENABLE, RST_OBJ_ENABLE, RST_BG_PAL, RST_OBJ_PAL, RST_OBJ_PAL};
    src_idle = 11;
    sink_idle = 64;

    script = '{
      shift_row(2'd0, 1'b0),                                          // both fifos empty
      cmd_row(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF),
      cmd_row(CMD_PUSH_BG, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_PUSH_BG, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),  // full, dropped
      shift_row(2'd3, 1'b0),
      cmd_row(CMD_PUSH_OBJ, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF),
      shift_row(2'd3, 1'b0),                                          // objects disabled
      reg_row(CFG_OBJ_ENABLE, 8'h01),
      reg_row(CFG_OBJ_PAL0, 8'h1B),
      reg_row(CFG_OBJ_PAL1, 8'hE4),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),    // behind opaque bg
      cmd_row(CMD_PUSH_OBJ, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      reg_row(CFG_BG_ENABLE, 8'h00),
      cmd_row(CMD_PUSH_OBJ, 8'h0F, 8'h33, 1'b1, 1'b1, 1'b0, 8'h80),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),    // transparent object
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),
      reg_row(CFG_BG_ENABLE, 8'h01),
      reg_row(CFG_BG_PAL, 8'hE4),
      cmd_row(CMD_PUSH_BG, 8'h00, 8'h0F, 1'b0, 1'b0, 1'b0, 8'h00),
      cmd_row(CMD_PUSH_OBJ, 8'hF0, 8'h0F, 1'b0, 1'b0, 1'b1, 8'h10),
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00),    // behind, bg colour 0
      cmd_row(CMD_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].is_write) load_register(script[r].reg_idx, script[r].reg_val);
      else send_pixel_cmd(script[r].item, script[r].typed, script[r].want);
    end

    for (int m = 0; m < 3; m++) begin
      src_idle  = (m == 0) ? 11 : (m == 1) ? 64 : 0;
      sink_idle = (m == 0) ? 64 : (m == 1) ? 11 : 0;
      for (int s = 0; s < SEGS_PER_MODE; s++) begin
        seg = m * SEGS_PER_MODE + s;
        p_bg = 8'($urandom);
        p_o0 = 8'($urandom);
        p_o1 = 8'($urandom);
        case (seg)
          0: begin
            en_bg = 1'b1; en_obj = 1'b1; p_bg = 8'h00; p_o0 = 8'h00; p_o1 = 8'h00;
          end
          1: begin
            en_bg = 1'b0; en_obj = 1'b1; p_bg = 8'hFF; p_o0 = 8'hFF; p_o1 = 8'hFF;
          end
          2: begin
            en_bg = 1'b1; en_obj = 1'b0;
          end
          3: begin
            en_bg = 1'b0; en_obj = 1'b0;
          end
          default: begin
            en_bg  = ($urandom_range(3) != 0);
            en_obj = ($urandom_range(3) != 0);
          end
        endcase
        load_register(CFG_BG_ENABLE, {7'd0, en_bg});
        load_register(CFG_OBJ_ENABLE, {7'd0, en_obj});
        load_register(CFG_BG_PAL, p_bg);
        load_register(CFG_OBJ_PAL0, p_o0);
        load_register(CFG_OBJ_PAL1, p_o1);
        // vary the push/shift mix so fill levels wander between empty and full
        bg_pct  = $urandom_range(8, 25);
        obj_pct = $urandom_range(8, 25);
        for (int n = 0; n < ITEMS_PER_SEG; n++) begin
          it = random_item(bg_pct, obj_pct);
          send_pixel_cmd(it, 1'b0, '0);
        end
      end
    end

    pix_in.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
